[rtl/core/mct_pkg.sv]
// Shared widths, codes and types of the mask centroid tracker.
`default_nettype none

package mct_pkg;

   // Field widths
   localparam int COORD_W    = 10;
   localparam int COUNT_W    = 21;
   localparam int SUM_W      = 30;
   localparam int MARGIN_W   = 8;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 21;

   // Frame limits; a pixel outside them counts as dark
   localparam int MAX_COLS = 1024;
   localparam int MAX_ROWS = 1024;

   // Default growth divisor for the active hysteresis
   localparam int GROW_DIVISOR = 6;

   // Lit count saturates here, sums stop with it
   localparam logic [COUNT_W-1:0] COUNT_CAP = 21'h10_0000;

   // Reset value of the deadband register
   localparam logic [MARGIN_W-1:0] MARGIN_RESET = 8'd5;

   // Depth of the frame queue between accumulator and divider
   localparam int QUEUE_DEPTH = 2;

   // Register indexes of the write port
   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_MARGIN   = 2'd0,
      CSR_REF_AREA = 2'd1,
      CSR_START_X  = 2'd2,
      CSR_START_Y  = 2'd3
   } csr_index_type;

   // Back end sequencer states
   typedef enum logic [1:0] {
      BK_IDLE,
      BK_DIV,
      BK_DONE
   } bk_state_type;

   // One finished frame: sums and lit count
   typedef struct packed {
      logic [SUM_W-1:0]   sum_col;
      logic [SUM_W-1:0]   sum_row;
      logic [COUNT_W-1:0] count;
   } job_type;

   // Static settings seen by the back end
   typedef struct packed {
      logic [MARGIN_W-1:0] margin;
      logic [COUNT_W-1:0]  reference_area;
   } cfg_type;

   // Center preload from a start register write
   typedef struct packed {
      logic               load_col;
      logic               load_row;
      logic [COORD_W-1:0] value;
   } load_type;

endpackage

`default_nettype wire

[rtl/core/mask_centroid_tracker.sv]
// Top level of the mask centroid tracker: register port, front end, queue, back end.
//
//  channel  | ports                                         | handshake
//  ---------+-----------------------------------------------+------------------------------
//  request  | req_col req_row req_lit req_frame_end         | start high, busy low
//  response | rsp_center_col rsp_center_row rsp_is_active   | rsp_valid, one cycle, no stall
//           | rsp_lit_count rsp_found                       |
//  csr      | csr_index csr_data                            | csr_we, no wait
//
// A pixel item is taken every cycle while busy is low; the accumulator adds
// it in that cycle. A frame's result follows its last pixel through queue pop,
// ten restoring divide steps (one quotient bit each), update, then the strobe.
// Two finished frames can wait in the queue; busy is high while it is full, and
// the back end takes one frame at a time, so a run of short frames slows input.
// Synchronous reset clears accumulators, queue, center, strobe; sets active flag.
`default_nettype none

module mask_centroid_tracker #(
   parameter int GROW_DIVISOR = mct_pkg::GROW_DIVISOR
) (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire logic                           start,
   output logic                                busy,
   input  wire logic [mct_pkg::COORD_W-1:0]    req_col,
   input  wire logic [mct_pkg::COORD_W-1:0]    req_row,
   input  wire logic                           req_lit,
   input  wire logic                           req_frame_end,
   output logic                                rsp_valid,
   output logic [mct_pkg::COORD_W-1:0]         rsp_center_col,
   output logic [mct_pkg::COORD_W-1:0]         rsp_center_row,
   output logic                                rsp_is_active,
   output logic [mct_pkg::COUNT_W-1:0]         rsp_lit_count,
   output logic                                rsp_found,
   input  wire logic                           csr_we,
   input  wire logic [mct_pkg::CSR_IDX_W-1:0]  csr_index,
   input  wire logic [mct_pkg::CSR_DATA_W-1:0] csr_data
);

   logic [mct_pkg::MARGIN_W-1:0] margin_ff, margin_in;
   logic [mct_pkg::COUNT_W-1:0]  ref_area_ff, ref_area_in;
   mct_pkg::load_type            load;
   mct_pkg::cfg_type             cfg;
   mct_pkg::job_type             push_job, head;
   logic                         accept, push, pop, not_empty, full;

   // Decode register writes
   always_comb begin
      margin_in     = margin_ff;
      ref_area_in   = ref_area_ff;
      load.load_col = 1'b0;
      load.load_row = 1'b0;
      load.value    = csr_data[mct_pkg::COORD_W-1:0];
      if (csr_we) begin
         unique case (mct_pkg::csr_index_type'(csr_index))
            mct_pkg::CSR_MARGIN:   margin_in     = csr_data[mct_pkg::MARGIN_W-1:0];
            mct_pkg::CSR_REF_AREA: ref_area_in   = csr_data[mct_pkg::COUNT_W-1:0];
            mct_pkg::CSR_START_X:  load.load_col = 1'b1;
            mct_pkg::CSR_START_Y:  load.load_row = 1'b1;
            default: ;
         endcase
      end
   end

   // Hold the configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         margin_ff   <= mct_pkg::MARGIN_RESET;
         ref_area_ff <= '0;
      end else begin
         margin_ff   <= margin_in;
         ref_area_ff <= ref_area_in;
      end
   end

   assign cfg.margin         = margin_ff;
   assign cfg.reference_area = ref_area_ff;

   // Stall input while the frame queue is full
   assign busy   = full;
   assign accept = start && !busy;

   mct_front u_front (
      .clock     (clock),
      .reset     (reset),
      .accept    (accept),
      .col       (req_col),
      .row       (req_row),
      .lit       (req_lit),
      .frame_end (req_frame_end),
      .push      (push),
      .job       (push_job)
   );

   mct_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_job  (push_job),
      .pop       (pop),
      .not_empty (not_empty),
      .full      (full),
      .head      (head)
   );

   mct_back #(
      .GROW_DIVISOR (GROW_DIVISOR)
   ) u_back (
      .clock          (clock),
      .reset          (reset),
      .job_valid      (not_empty),
      .job            (head),
      .pop            (pop),
      .cfg            (cfg),
      .load           (load),
      .rsp_valid      (rsp_valid),
      .rsp_center_col (rsp_center_col),
      .rsp_center_row (rsp_center_row),
      .rsp_is_active  (rsp_is_active),
      .rsp_lit_count  (rsp_lit_count),
      .rsp_found      (rsp_found)
   );

endmodule

`default_nettype wire

[rtl/core/mct_front.sv]
// Front end: per-pixel accumulation of coordinate sums and lit count.
`default_nettype none

module mct_front (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire logic                        accept,
   input  wire logic [mct_pkg::COORD_W-1:0] col,
   input  wire logic [mct_pkg::COORD_W-1:0] row,
   input  wire logic                        lit,
   input  wire logic                        frame_end,
   output logic                             push,
   output mct_pkg::job_type                 job
);

   logic [mct_pkg::SUM_W-1:0]   sum_col_ff, sum_col_in;
   logic [mct_pkg::SUM_W-1:0]   sum_row_ff, sum_row_in;
   logic [mct_pkg::COUNT_W-1:0] count_ff, count_in;
   logic                        hit;

   // Count a lit pixel inside the frame while the count is below its cap
   always_comb begin
      hit = lit
            && (32'(col) < 32'(mct_pkg::MAX_COLS))
            && (32'(row) < 32'(mct_pkg::MAX_ROWS))
            && (count_ff < mct_pkg::COUNT_CAP);
      sum_col_in = sum_col_ff;
      sum_row_in = sum_row_ff;
      count_in   = count_ff;
      if (hit) begin
         sum_col_in = sum_col_ff + mct_pkg::SUM_W'(col);
         sum_row_in = sum_row_ff + mct_pkg::SUM_W'(row);
         count_in   = count_ff + mct_pkg::COUNT_W'(1);
      end
   end

   // Hand the frame, last pixel included, to the queue
   assign push        = accept && frame_end;
   assign job.sum_col = sum_col_in;
   assign job.sum_row = sum_row_in;
   assign job.count   = count_in;

   // Advance the accumulators, clear them after the last pixel
   always_ff @(posedge clock) begin
      if (reset) begin
         sum_col_ff <= '0;
         sum_row_ff <= '0;
         count_ff   <= '0;
      end else if (accept) begin
         if (frame_end) begin
            sum_col_ff <= '0;
            sum_row_ff <= '0;
            count_ff   <= '0;
         end else begin
            sum_col_ff <= sum_col_in;
            sum_row_ff <= sum_row_in;
            count_ff   <= count_in;
         end
      end
   end

endmodule

`default_nettype wire

[rtl/core/mct_queue.sv]
// Short queue of finished frames between front and back end.
`default_nettype none

module mct_queue (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             push,
   input  wire mct_pkg::job_type push_job,
   input  wire logic             pop,
   output logic                  not_empty,
   output logic                  full,
   output mct_pkg::job_type      head
);

   localparam int PTR_W  = (mct_pkg::QUEUE_DEPTH > 1) ? $clog2(mct_pkg::QUEUE_DEPTH) : 1;
   localparam int FILL_W = $clog2(mct_pkg::QUEUE_DEPTH + 1);
   localparam logic [PTR_W-1:0]  LAST_PTR = PTR_W'(mct_pkg::QUEUE_DEPTH - 1);
   localparam logic [FILL_W-1:0] DEPTH    = FILL_W'(mct_pkg::QUEUE_DEPTH);

   mct_pkg::job_type  entry_ff [mct_pkg::QUEUE_DEPTH];
   logic [PTR_W-1:0]  wr_ptr_ff, rd_ptr_ff;
   logic [FILL_W-1:0] fill_ff;

   assign not_empty = (fill_ff != '0);
   assign full      = (fill_ff == DEPTH);
   assign head      = entry_ff[rd_ptr_ff];

   // Store an item at the write pointer
   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_job;
      end
   end

   // Advance pointers and fill level
   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         fill_ff   <= '0;
      end else begin
         if (push) begin
            wr_ptr_ff <= (wr_ptr_ff == LAST_PTR) ? '0 : wr_ptr_ff + PTR_W'(1);
         end
         if (pop) begin
            rd_ptr_ff <= (rd_ptr_ff == LAST_PTR) ? '0 : rd_ptr_ff + PTR_W'(1);
         end
         if (push && !pop) begin
            fill_ff <= fill_ff + FILL_W'(1);
         end else if (pop && !push) begin
            fill_ff <= fill_ff - FILL_W'(1);
         end
      end
   end

endmodule

`default_nettype wire

[rtl/core/mct_back.sv]
// Back end: centroid division, deadband, active hysteresis and result strobe.
`default_nettype none

module mct_back #(
   parameter int GROW_DIVISOR = mct_pkg::GROW_DIVISOR
) (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire logic                         job_valid,
   input  wire mct_pkg::job_type             job,
   output logic                              pop,
   input  wire mct_pkg::cfg_type             cfg,
   input  wire mct_pkg::load_type            load,
   output logic                              rsp_valid,
   output logic [mct_pkg::COORD_W-1:0]       rsp_center_col,
   output logic [mct_pkg::COORD_W-1:0]       rsp_center_row,
   output logic                              rsp_is_active,
   output logic [mct_pkg::COUNT_W-1:0]       rsp_lit_count,
   output logic                              rsp_found
);

   localparam int COORD_W = mct_pkg::COORD_W;
   localparam int COUNT_W = mct_pkg::COUNT_W;
   localparam int SUM_W   = mct_pkg::SUM_W;
   localparam int STEP_W  = $clog2(COORD_W);
   localparam int CMP_W   = COORD_W + 1;
   localparam int GROW_W  = COUNT_W + 1;

   // Reciprocals for area / GROW_DIVISOR and area / (2 * GROW_DIVISOR)
   localparam int     RECIP_SHIFT = COUNT_W + $clog2(2 * GROW_DIVISOR) + 1;
   localparam int     RECIP_W     = RECIP_SHIFT + 1;
   localparam int     PROD_W      = COUNT_W + RECIP_W;
   localparam longint HI_RECIP    =
      ((longint'(1) << RECIP_SHIFT) + GROW_DIVISOR - 1) / GROW_DIVISOR;
   localparam longint LO_RECIP    =
      ((longint'(1) << RECIP_SHIFT) + 2 * GROW_DIVISOR - 1) / (2 * GROW_DIVISOR);

   localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(COORD_W - 1);

   mct_pkg::bk_state_type state_ff, state_in;

   logic [SUM_W-1:0]   rem_col_ff, rem_col_in;
   logic [SUM_W-1:0]   rem_row_ff, rem_row_in;
   logic [SUM_W-1:0]   div_sh_ff, div_sh_in;
   logic [COORD_W-1:0] q_col_ff, q_col_in;
   logic [COORD_W-1:0] q_row_ff, q_row_in;
   logic [STEP_W-1:0]  step_ff, step_in;
   logic [COUNT_W-1:0] count_ff, count_in;
   logic [COORD_W-1:0] cur_col_ff, cur_col_in;
   logic [COORD_W-1:0] cur_row_ff, cur_row_in;
   logic               active_ff, active_in;
   logic               valid_ff, valid_in;
   logic [PROD_W-1:0]  hi_prod_ff, lo_prod_ff;

   logic [GROW_W-1:0]  grow_hi, grow_lo;
   logic               move_col, move_row;

   // Thresholds by reciprocal multiply, registered
   always_ff @(posedge clock) begin
      hi_prod_ff <= PROD_W'(cfg.reference_area) * PROD_W'(HI_RECIP);
      lo_prod_ff <= PROD_W'(cfg.reference_area) * PROD_W'(LO_RECIP);
   end

   // Hold the state register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= mct_pkg::BK_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // Sequence: take a frame, divide one quotient bit a cycle, then update and strobe
   always_comb begin
      state_in   = state_ff;
      pop        = 1'b0;
      rem_col_in = rem_col_ff;
      rem_row_in = rem_row_ff;
      div_sh_in  = div_sh_ff;
      q_col_in   = q_col_ff;
      q_row_in   = q_row_ff;
      step_in    = step_ff;
      count_in   = count_ff;
      cur_col_in = cur_col_ff;
      cur_row_in = cur_row_ff;
      active_in  = active_ff;
      valid_in   = 1'b0;

      grow_hi  = GROW_W'(cfg.reference_area) + GROW_W'(hi_prod_ff[RECIP_SHIFT +: COUNT_W]);
      grow_lo  = GROW_W'(cfg.reference_area) + GROW_W'(lo_prod_ff[RECIP_SHIFT +: COUNT_W]);
      move_col = (CMP_W'(q_col_ff) > CMP_W'(cur_col_ff) + CMP_W'(cfg.margin))
                 || (CMP_W'(q_col_ff) + CMP_W'(cfg.margin) < CMP_W'(cur_col_ff));
      move_row = (CMP_W'(q_row_ff) > CMP_W'(cur_row_ff) + CMP_W'(cfg.margin))
                 || (CMP_W'(q_row_ff) + CMP_W'(cfg.margin) < CMP_W'(cur_row_ff));

      unique case (state_ff)
         mct_pkg::BK_IDLE: begin
            if (job_valid) begin
               pop        = 1'b1;
               rem_col_in = job.sum_col;
               rem_row_in = job.sum_row;
               div_sh_in  = SUM_W'({job.count, {(COORD_W - 1){1'b0}}});
               count_in   = job.count;
               step_in    = LAST_STEP;
               state_in   = mct_pkg::BK_DIV;
            end
         end
         mct_pkg::BK_DIV: begin
            // Quotient fits the coordinate width since each term is a coordinate
            q_col_in = {q_col_ff[COORD_W-2:0], (rem_col_ff >= div_sh_ff)};
            q_row_in = {q_row_ff[COORD_W-2:0], (rem_row_ff >= div_sh_ff)};
            if (rem_col_ff >= div_sh_ff) begin
               rem_col_in = rem_col_ff - div_sh_ff;
            end
            if (rem_row_ff >= div_sh_ff) begin
               rem_row_in = rem_row_ff - div_sh_ff;
            end
            div_sh_in = div_sh_ff >> 1;
            step_in   = step_ff - STEP_W'(1);
            if (step_ff == '0) begin
               state_in = mct_pkg::BK_DONE;
            end
         end
         mct_pkg::BK_DONE: begin
            // Move each coordinate only outside the deadband; empty frame keeps it
            if ((count_ff != '0) && move_col) begin
               cur_col_in = q_col_ff;
            end
            if ((count_ff != '0) && move_row) begin
               cur_row_in = q_row_ff;
            end
            if (GROW_W'(count_ff) > grow_hi) begin
               active_in = 1'b1;
            end else if (GROW_W'(count_ff) < grow_lo) begin
               active_in = 1'b0;
            end
            valid_in = 1'b1;
            state_in = mct_pkg::BK_IDLE;
         end
         default: begin
            state_in = mct_pkg::BK_IDLE;
         end
      endcase

      // Start register writes preload the center
      if (load.load_col) begin
         cur_col_in = load.value;
      end
      if (load.load_row) begin
         cur_row_in = load.value;
      end
   end

   // Divider datapath
   always_ff @(posedge clock) begin
      rem_col_ff <= rem_col_in;
      rem_row_ff <= rem_row_in;
      div_sh_ff  <= div_sh_in;
      q_col_ff   <= q_col_in;
      q_row_ff   <= q_row_in;
      step_ff    <= step_in;
   end

   // Tracked state and result strobe
   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff   <= '0;
         cur_col_ff <= '0;
         cur_row_ff <= '0;
         active_ff  <= 1'b1;
         valid_ff   <= 1'b0;
      end else begin
         count_ff   <= count_in;
         cur_col_ff <= cur_col_in;
         cur_row_ff <= cur_row_in;
         active_ff  <= active_in;
         valid_ff   <= valid_in;
      end
   end

   assign rsp_valid      = valid_ff;
   assign rsp_center_col = cur_col_ff;
   assign rsp_center_row = cur_row_ff;
   assign rsp_is_active  = active_ff;
   assign rsp_lit_count  = count_ff;
   assign rsp_found      = (count_ff != '0);

endmodule

`default_nettype wire

[rtl/core/mct_checker.sv]
// Port-level checks of the mask centroid tracker, bound to the top level.
`default_nettype none

module mct_checker (
   input wire logic                        clock,
   input wire logic                        reset,
   input wire logic                        rsp_valid,
   input wire logic [mct_pkg::COORD_W-1:0] rsp_center_col,
   input wire logic [mct_pkg::COORD_W-1:0] rsp_center_row,
   input wire logic [mct_pkg::COUNT_W-1:0] rsp_lit_count,
   input wire logic                        rsp_found
);

   // Results are single-cycle strobes, never adjacent
   a_strobe_single : assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid)
      else $error("result strobe held for more than one cycle");

   // Found flag agrees with the lit count
   a_found_count : assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_found == (rsp_lit_count != '0)))
      else $error("found flag disagrees with lit count");

   // An empty frame leaves the center where it was
   a_empty_hold : assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_found) |->
         (rsp_center_col == $past(rsp_center_col))
         && (rsp_center_row == $past(rsp_center_row)))
      else $error("center moved on an empty frame");

   // Lit count never passes its cap
   a_count_cap : assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_lit_count <= mct_pkg::COUNT_CAP))
      else $error("lit count above cap");

endmodule

bind mask_centroid_tracker mct_checker u_mct_checker (.*);

`default_nettype wire

[bench/tb_mask_centroid_tracker.sv]
// Self-checking bench for the mask centroid tracker: directed frames and random frames.
`timescale 1ns / 100ps

module tb_mask_centroid_tracker;

   // Cycles to wait after the last result, as slack before the next step
   localparam int DRAIN_CYCLES = 20;

   typedef struct packed {
      logic [mct_pkg::COORD_W-1:0] col;
      logic [mct_pkg::COORD_W-1:0] row;
      logic                        lit;
      logic                        frame_end;
   } mask_pixel_type;

   typedef struct packed {
      logic [mct_pkg::COORD_W-1:0] center_col;
      logic [mct_pkg::COORD_W-1:0] center_row;
      logic                        is_active;
      logic [mct_pkg::COUNT_W-1:0] lit_count;
      logic                        found;
   } frame_summary_type;

   logic                           clock = 1'b0;
   logic                           reset;
   logic                           start;
   logic                           busy;
   logic [mct_pkg::COORD_W-1:0]    req_col;
   logic [mct_pkg::COORD_W-1:0]    req_row;
   logic                           req_lit;
   logic                           req_frame_end;
   logic                           rsp_valid;
   logic [mct_pkg::COORD_W-1:0]    rsp_center_col;
   logic [mct_pkg::COORD_W-1:0]    rsp_center_row;
   logic                           rsp_is_active;
   logic [mct_pkg::COUNT_W-1:0]    rsp_lit_count;
   logic                           rsp_found;
   logic                           csr_we;
   logic [mct_pkg::CSR_IDX_W-1:0]  csr_index;
   logic [mct_pkg::CSR_DATA_W-1:0] csr_data;

   // Tracker state kept by the bench, at reset values
   logic [mct_pkg::SUM_W-1:0]    acc_col    = '0;
   logic [mct_pkg::SUM_W-1:0]    acc_row    = '0;
   logic [mct_pkg::COUNT_W-1:0]  acc_count  = '0;
   logic [mct_pkg::COORD_W-1:0]  trk_col    = '0;
   logic [mct_pkg::COORD_W-1:0]  trk_row    = '0;
   logic                         trk_active = 1'b1;
   logic [mct_pkg::MARGIN_W-1:0] trk_margin = mct_pkg::MARGIN_RESET;
   logic [mct_pkg::COUNT_W-1:0]  trk_area   = '0;

   frame_summary_type pending_frames[$];
   int unsigned       mismatch_count = 0;
   bit                idle_enable    = 1'b1;

   mask_centroid_tracker DUT (
      .clock          (clock),
      .reset          (reset),
      .start          (start),
      .busy           (busy),
      .req_col        (req_col),
      .req_row        (req_row),
      .req_lit        (req_lit),
      .req_frame_end  (req_frame_end),
      .rsp_valid      (rsp_valid),
      .rsp_center_col (rsp_center_col),
      .rsp_center_row (rsp_center_row),
      .rsp_is_active  (rsp_is_active),
      .rsp_lit_count  (rsp_lit_count),
      .rsp_found      (rsp_found),
      .csr_we         (csr_we),
      .csr_index      (csr_index),
      .csr_data       (csr_data)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // Keep a center coordinate unless the new one lies beyond the margin
   function automatic logic [mct_pkg::COORD_W-1:0] apply_deadband(
         logic [mct_pkg::COORD_W-1:0] held, logic [mct_pkg::COORD_W-1:0] fresh);
      int h;
      int f;
      int m;
      h = held;
      f = fresh;
      m = trk_margin;
      return ((f > h + m) || (f < h - m)) ? fresh : held;
   endfunction

   // Accumulate one pixel; on the last pixel of a frame queue the expected summary
   function automatic void track_pixel(mask_pixel_type px);
      frame_summary_type res;
      logic [31:0]       quotient;
      logic [31:0]       grow_hi;
      logic [31:0]       grow_lo;
      if (px.lit && px.col < mct_pkg::MAX_COLS && px.row < mct_pkg::MAX_ROWS
          && acc_count < mct_pkg::COUNT_CAP) begin
         acc_col   = acc_col + mct_pkg::SUM_W'(px.col);
         acc_row   = acc_row + mct_pkg::SUM_W'(px.row);
         acc_count = acc_count + mct_pkg::COUNT_W'(1);
      end
      if (px.frame_end) begin
         if (acc_count != 0) begin
            quotient = 32'(acc_col) / 32'(acc_count);
            trk_col  = apply_deadband(trk_col, quotient[mct_pkg::COORD_W-1:0]);
            quotient = 32'(acc_row) / 32'(acc_count);
            trk_row  = apply_deadband(trk_row, quotient[mct_pkg::COORD_W-1:0]);
         end
         grow_hi = 32'(trk_area) + 32'(trk_area) / 32'(mct_pkg::GROW_DIVISOR);
         grow_lo = 32'(trk_area) + 32'(trk_area) / 32'(2 * mct_pkg::GROW_DIVISOR);
         if (32'(acc_count) > grow_hi)
            trk_active = 1'b1;
         else if (32'(acc_count) < grow_lo)
            trk_active = 1'b0;
         res.center_col = trk_col;
         res.center_row = trk_row;
         res.is_active  = trk_active;
         res.lit_count  = acc_count;
         res.found      = (acc_count != 0);
         pending_frames.push_back(res);
         acc_col   = '0;
         acc_row   = '0;
         acc_count = '0;
      end
   endfunction

   // Send one pixel item, with an occasional idle burst first
   task automatic send_pixel(input logic [mct_pkg::COORD_W-1:0] col,
                             input logic [mct_pkg::COORD_W-1:0] row,
                             input logic lit, input logic frame_end);
      mask_pixel_type px;
      px = '{col, row, lit, frame_end};
      if (idle_enable && $urandom_range(0, 5) == 0) begin
         start <= 1'b0;
         repeat ($urandom_range(1, 10)) @(posedge clock);
      end
      req_col       <= col;
      req_row       <= row;
      req_lit       <= lit;
      req_frame_end <= frame_end;
      start         <= 1'b1;
      @(posedge clock);
      while (busy) @(posedge clock);
      track_pixel(px);
   endtask

   // Write the selected registers back to back (bit i selects register i)
   task automatic configure(input logic [3:0] sel,
                            input logic [mct_pkg::CSR_DATA_W-1:0] margin_w,
                            input logic [mct_pkg::CSR_DATA_W-1:0] area_w,
                            input logic [mct_pkg::CSR_DATA_W-1:0] sx_w,
                            input logic [mct_pkg::CSR_DATA_W-1:0] sy_w);
      logic [mct_pkg::CSR_DATA_W-1:0] words[4];
      words = '{margin_w, area_w, sx_w, sy_w};
      for (int i = 0; i < 4; i++) begin
         if (sel[i]) begin
            csr_we    <= 1'b1;
            csr_index <= mct_pkg::csr_index_type'(i);
            csr_data  <= words[i];
            @(posedge clock);
            unique case (mct_pkg::csr_index_type'(i))
               mct_pkg::CSR_MARGIN:   trk_margin = words[i][mct_pkg::MARGIN_W-1:0];
               mct_pkg::CSR_REF_AREA: trk_area   = words[i][mct_pkg::COUNT_W-1:0];
               mct_pkg::CSR_START_X:  trk_col    = words[i][mct_pkg::COORD_W-1:0];
               mct_pkg::CSR_START_Y:  trk_row    = words[i][mct_pkg::COORD_W-1:0];
            endcase
         end
      end
      csr_we <= 1'b0;
   endtask

   // Stop sending and wait until every queued frame has reported
   task automatic settle();
      start <= 1'b0;
      while (pending_frames.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   // Reset values: margin 5, area 0, center at origin, flag set
   task automatic test_reset_defaults();
      send_pixel(10'd1023, 10'd1023, 1'b1, 1'b0);
      send_pixel(10'd1023, 10'd1023, 1'b1, 1'b1);
      send_pixel(10'd0, 10'd0, 1'b1, 1'b1);
   endtask

   // Frame with no lit pixel: center held, nothing found
   task automatic test_empty_frame();
      send_pixel(10'd512, 10'd77, 1'b0, 1'b0);
      send_pixel(10'd3, 10'd900, 1'b0, 1'b1);
   endtask

   // Deadband edges, margin extremes, start loads and truncating division
   task automatic test_deadband();
      settle();
      configure(4'b1101, {13'h1FFF, 8'd3}, '0, {11'h7FF, 10'd100}, {11'h2AA, 10'd200});
      send_pixel(10'd103, 10'd204, 1'b1, 1'b1);
      send_pixel(10'd96, 10'd196, 1'b1, 1'b1);
      settle();
      configure(4'b0001, {13'h1555, 8'd0}, '0, '0, '0);
      send_pixel(10'd97, 10'd196, 1'b1, 1'b1);
      send_pixel(10'd1, 10'd0, 1'b1, 1'b0);
      send_pixel(10'd2, 10'd1, 1'b1, 1'b1);
      settle();
      configure(4'b1101, 21'd255, '0, 21'd97, 21'd1023);
      send_pixel(10'd352, 10'd768, 1'b1, 1'b1);
      send_pixel(10'd353, 10'd767, 1'b1, 1'b1);
   endtask

   // Walk the active flag through clear, hold, set, hold, clear
   task automatic test_hysteresis();
      settle();
      configure(4'b0010, '0, 21'd1, '0, '0);
      send_pixel(10'd500, 10'd600, 1'b0, 1'b1);
      send_pixel(10'd500, 10'd600, 1'b1, 1'b1);
      send_pixel(10'd500, 10'd600, 1'b1, 1'b0);
      send_pixel(10'd501, 10'd601, 1'b1, 1'b1);
      send_pixel(10'd499, 10'd599, 1'b1, 1'b1);
      send_pixel(10'd500, 10'd600, 1'b0, 1'b1);
   endtask

   // Random frames in phases of random settings; the last phase runs without gaps
   task automatic test_random_frames();
      int                             sent;
      int                             len;
      int                             density;
      int                             spread;
      int                             cx;
      int                             cy;
      int                             vc;
      int                             vr;
      logic [mct_pkg::MARGIN_W-1:0]   margin;
      logic [mct_pkg::CSR_DATA_W-1:0] area_w;
      for (int phase = 0; phase < 6; phase++) begin
         settle();
         case ($urandom_range(0, 5))
            0:       area_w = '0;
            1:       area_w = '1;
            2:       area_w = mct_pkg::CSR_DATA_W'(mct_pkg::COUNT_CAP);
            default: area_w = mct_pkg::CSR_DATA_W'($urandom_range(1, 24));
         endcase
         case ($urandom_range(0, 3))
            0:       margin = '0;
            1:       margin = '1;
            2:       margin = mct_pkg::MARGIN_W'($urandom_range(0, 40));
            default: margin = mct_pkg::MARGIN_W'($urandom);
         endcase
         configure((phase == 0) ? 4'hF : 4'($urandom_range(1, 15)),
                   {13'($urandom), margin}, area_w, 21'($urandom), 21'($urandom));
         idle_enable = (phase < 5) && ($urandom_range(0, 2) != 0);
         sent = 0;
         while (sent < 200) begin
            len     = ($urandom_range(0, 7) == 0) ? $urandom_range(17, 80)
                                                  : $urandom_range(1, 16);
            density = $urandom_range(0, 100);
            spread  = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 60);
            cx      = $urandom_range(0, 1023);
            cy      = $urandom_range(0, 1023);
            for (int n = 0; n < len; n++) begin
               // Spread zero scatters over the whole frame, else cluster around a point
               if (spread == 0) begin
                  vc = $urandom_range(0, 1023);
                  vr = $urandom_range(0, 1023);
               end else begin
                  vc = cx + int'($urandom_range(0, 2 * spread)) - spread;
                  vr = cy + int'($urandom_range(0, 2 * spread)) - spread;
                  vc = (vc < 0) ? 0 : (vc > 1023) ? 1023 : vc;
                  vr = (vr < 0) ? 0 : (vr > 1023) ? 1023 : vr;
               end
               send_pixel(mct_pkg::COORD_W'(vc), mct_pkg::COORD_W'(vr),
                          $urandom_range(0, 99) < density, n == len - 1);
            end
            sent += len;
         end
      end
   endtask

   // Compare one field and count a mismatch
   task automatic check_field(input string name, input logic [31:0] want,
                              input logic [31:0] got);
      if (got !== want) begin
         $error("%s mismatch: expected %0d, actual %0d", name, want, got);
         mismatch_count++;
      end
   endtask

   // Match each strobed result against the oldest expected frame
   always @(posedge clock) begin : check_results
      frame_summary_type want;
      if (!reset && rsp_valid) begin
         if (pending_frames.size() == 0) begin
            $error("unexpected result: center_col %0d center_row %0d lit_count %0d",
                   rsp_center_col, rsp_center_row, rsp_lit_count);
            mismatch_count++;
         end else begin
            want = pending_frames.pop_front();
            check_field("center_col", want.center_col, rsp_center_col);
            check_field("center_row", want.center_row, rsp_center_row);
            check_field("is_active", want.is_active, rsp_is_active);
            check_field("lit_count", want.lit_count, rsp_lit_count);
            check_field("found", want.found, rsp_found);
         end
      end
   end

   initial begin
      reset         <= 1'b1;
      start         <= 1'b0;
      req_col       <= '0;
      req_row       <= '0;
      req_lit       <= 1'b0;
      req_frame_end <= 1'b0;
      csr_we        <= 1'b0;
      csr_index     <= mct_pkg::CSR_MARGIN;
      csr_data      <= '0;
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      test_reset_defaults();
      test_empty_frame();
      test_deadband();
      test_hysteresis();
      test_random_frames();
      settle();
      if (mismatch_count == 0)
         $display("Testbench completed without errors");
      else
         $display("Testbench completed WITH ERRORS");
      $finish;
   end

   // Hard stop well beyond the slowest correct run
   initial begin
      #10_000_000;
      $display("Testbench completed WITH ERRORS");
      $finish;
   end

endmodule

[mask_centroid_tracker.f]
rtl/core/mct_pkg.sv
rtl/core/mct_front.sv
rtl/core/mct_queue.sv
rtl/core/mct_back.sv
rtl/core/mask_centroid_tracker.sv
rtl/core/mct_checker.sv
bench/tb_mask_centroid_tracker.sv
